// File: src/dat_pkg.sv
// Shared types and constants for the device address table.
`default_nettype none

package dat_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ADDR_W          = 48;
    localparam int KIND_W          = 8;
    localparam int IDX_W           = 8;
    localparam int TIME_W          = 32;
    localparam int RSSI_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int USED_W          = 5;

    typedef enum logic [2:0] {
        CMD_FIND   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_SET_EN = 3'd3,
        CMD_MARK   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_DUP  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0]        addr;
        logic [KIND_W-1:0]        kind;
        logic                     enable;
        logic [TIME_W-1:0]        last_seen;
        logic signed [RSSI_W-1:0] rssi;
    } t_entry;

endpackage

`default_nettype wire

// File: src/dat_mem.sv
// Entry RAM with one write port and a separate registered read port.
`default_nettype none

module dat_mem #(
    parameter int DEPTH = dat_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rd_en,
    input  wire logic [AW-1:0]   i_rd_addr,
    output dat_pkg::t_entry      o_rd_data,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire dat_pkg::t_entry i_wr_data
);
    import dat_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/dat_ctrl.sv
// Command sequencer: scan, shift and read-modify-write over the entry RAM.
`default_nettype none

module dat_ctrl #(
    parameter int MAX_ENTRIES = dat_pkg::MAX_ENTRIES_DEF,
    parameter int IW          = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic [dat_pkg::ADDR_W-1:0]    i_dev_address,
    input  wire logic [dat_pkg::KIND_W-1:0]    i_address_kind,
    input  wire logic [dat_pkg::IDX_W-1:0]     i_entry_index,
    input  wire logic                          i_enable_flag,
    input  wire logic [dat_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic signed [dat_pkg::RSSI_W-1:0] i_signal_strength,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dat_pkg::STATUS_W-1:0]       o_status,
    output logic [dat_pkg::IDX_W-1:0]          o_found_index,
    output logic [dat_pkg::TIME_W-1:0]         o_interval_ms,
    output logic [dat_pkg::USED_W-1:0]         o_entries_in_use,
    output logic                               o_mem_rd_en,
    output logic [IW-1:0]                      o_mem_rd_addr,
    input  wire dat_pkg::t_entry               i_mem_rd_data,
    output logic                               o_mem_wr_en,
    output logic [IW-1:0]                      o_mem_wr_addr,
    output dat_pkg::t_entry                    o_mem_wr_data
);
    import dat_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = ((IDX_W > CW) ? IDX_W : CW) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RMW_RD,
        S_RMW_WR,
        S_PUT
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_ptr, n_ptr;
    logic                     r_dv, n_dv;
    logic [IW-1:0]            r_cidx, n_cidx;
    t_cmd                     r_cmd, n_cmd;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_en, n_en;
    logic [TIME_W-1:0]        r_now, n_now;
    logic signed [RSSI_W-1:0] r_rssi, n_rssi;
    t_status                  r_st, n_st;
    logic [IDX_W-1:0]         r_fidx, n_fidx;
    logic [TIME_W-1:0]        r_ivl, n_ivl;
    logic                     r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]      r_ostatus, n_ostatus;
    logic [IDX_W-1:0]         r_ofidx, n_ofidx;
    logic [TIME_W-1:0]        r_oivl, n_oivl;
    logic [USED_W-1:0]        r_oused, n_oused;

    logic                     in_range;
    logic                     hit;
    t_entry                   new_entry;

    assign in_range = (XW'(r_idx) < XW'(r_count)) ? 1'b1 : 1'b0;
    assign hit      = r_dv && (i_mem_rd_data.addr == r_addr)
                      && (i_mem_rd_data.kind == r_kind);

    always_comb begin
        new_entry           = '0;
        new_entry.addr      = r_addr;
        new_entry.kind      = r_kind;
        new_entry.enable    = 1'b1;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_dv      = r_dv;
        n_cidx    = r_cidx;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_en      = r_en;
        n_now     = r_now;
        n_rssi    = r_rssi;
        n_st      = r_st;
        n_fidx    = r_fidx;
        n_ivl     = r_ivl;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ofidx   = r_ofidx;
        n_oivl    = r_oivl;
        n_oused   = r_oused;

        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_ptr[IW-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_cidx;
        o_mem_wr_data = i_mem_rd_data;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = t_cmd'(i_cmd);
                    n_addr = i_dev_address;
                    n_kind = i_address_kind;
                    n_idx  = i_entry_index;
                    n_en   = i_enable_flag;
                    n_now  = i_now_ms;
                    n_rssi = i_signal_strength;
                    n_st   = ST_MISS;
                    n_fidx = '0;
                    n_ivl  = '0;
                    n_ptr  = '0;
                    n_dv   = 1'b0;
                    n_state = S_PUT;
                    case (t_cmd'(i_cmd))
                        CMD_FIND, CMD_ADD: begin
                            n_state = S_SCAN;
                        end
                        CMD_REMOVE: begin
                            if (XW'(i_entry_index) < XW'(r_count)) begin
                                n_ptr   = CW'(i_entry_index) + CW'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_SET_EN: begin
                            if (XW'(i_entry_index) < XW'(r_count)) begin
                                n_state = S_RMW_RD;
                            end
                        end
                        CMD_MARK: begin
                            if (XW'(i_entry_index) < XW'(r_count)) begin
                                n_state = S_RMW_RD;
                            end else begin
                                n_ivl = '1;
                            end
                        end
                        default: begin
                            n_state = S_PUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_st    = (r_cmd == CMD_ADD) ? ST_DUP : ST_OK;
                    n_fidx  = (r_cmd == CMD_ADD) ? '0 : IDX_W'(r_cidx);
                    n_state = S_PUT;
                end else if (r_ptr < r_count) begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = r_ptr[IW-1:0];
                    n_cidx        = r_ptr[IW-1:0];
                    n_dv          = 1'b1;
                    n_ptr         = r_ptr + CW'(1);
                end else begin
                    n_dv    = 1'b0;
                    n_state = S_PUT;
                    if (r_cmd == CMD_FIND) begin
                        n_st = ST_MISS;
                    end else if (r_count == CW'(MAX_ENTRIES)) begin
                        n_st = ST_FULL;
                    end else begin
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_addr = r_count[IW-1:0];
                        o_mem_wr_data = new_entry;
                        n_count       = r_count + CW'(1);
                        n_fidx        = IDX_W'(r_count);
                        n_st          = ST_OK;
                    end
                end
            end
            S_SHIFT: begin
                if (r_dv) begin
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_addr = r_cidx - IW'(1);
                    o_mem_wr_data = i_mem_rd_data;
                end
                if (r_ptr < r_count) begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = r_ptr[IW-1:0];
                    n_cidx        = r_ptr[IW-1:0];
                    n_dv          = 1'b1;
                    n_ptr         = r_ptr + CW'(1);
                end else begin
                    n_dv    = 1'b0;
                    n_count = r_count - CW'(1);
                    n_st    = ST_OK;
                    n_state = S_PUT;
                end
            end
            S_RMW_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = r_idx[IW-1:0];
                n_state       = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_idx[IW-1:0];
                o_mem_wr_data = i_mem_rd_data;
                if (r_cmd == CMD_SET_EN) begin
                    o_mem_wr_data.enable = r_en;
                end else begin
                    o_mem_wr_data.last_seen = r_now;
                    o_mem_wr_data.rssi      = r_rssi;
                    n_ivl = (i_mem_rd_data.last_seen == '0) ? '1
                            : (r_now - i_mem_rd_data.last_seen);
                end
                n_st    = ST_OK;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ofidx   = r_fidx;
                    n_oivl    = r_ivl;
                    n_oused   = USED_W'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_ovalid <= n_ovalid;
        end
        r_ptr     <= n_ptr;
        r_cidx    <= n_cidx;
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_kind    <= n_kind;
        r_idx     <= n_idx;
        r_en      <= n_en;
        r_now     <= n_now;
        r_rssi    <= n_rssi;
        r_st      <= n_st;
        r_fidx    <= n_fidx;
        r_ivl     <= n_ivl;
        r_ostatus <= n_ostatus;
        r_ofidx   <= n_ofidx;
        r_oivl    <= n_oivl;
        r_oused   <= n_oused;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_found_index    = r_ofidx;
    assign o_interval_ms    = r_oivl;
    assign o_entries_in_use = r_oused;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_ENTRIES)
        else $error("Entry count exceeds table depth.");

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> (r_state == S_SCAN || r_state == S_SHIFT || r_state == S_RMW_WR))
        else $error("Entry RAM written outside a command.");

    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_state == S_PUT))
        else $error("Entry count changed without a finished command.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("Sequencer stayed idle after accepting a beat.");

    a_range_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW_RD) |-> in_range)
        else $error("Read-modify-write started on an index outside the table.");

endmodule

`default_nettype wire

// File: src/device_address_table_unit.sv
// Top level of the device address table: command sequencer and entry RAM.
//
// A compact list of up to MAX_ENTRIES device addresses kept packed at indices
// 0 to entries_in_use-1 in one RAM with separate read and write ports and a
// registered read. Each input beat carries one command and yields exactly one
// result beat. Find and add scan the RAM one entry per cycle; remove copies
// each later entry down one place; set_enabled and mark_seen read, modify and
// write one entry; rejected commands go straight to the result. The RAM
// serializes all of this, one command at a time. A finished result waits in
// the output register while the next command is accepted.
`default_nettype none

module device_address_table_unit #(
    parameter int MAX_ENTRIES = dat_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [2:0]                    i_cmd,
    input  wire logic [dat_pkg::ADDR_W-1:0]    i_dev_address,
    input  wire logic [dat_pkg::KIND_W-1:0]    i_address_kind,
    input  wire logic [dat_pkg::IDX_W-1:0]     i_entry_index,
    input  wire logic                          i_enable_flag,
    input  wire logic [dat_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic signed [dat_pkg::RSSI_W-1:0] i_signal_strength,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [dat_pkg::STATUS_W-1:0]       o_status,
    output logic [dat_pkg::IDX_W-1:0]          o_found_index,
    output logic [dat_pkg::TIME_W-1:0]         o_interval_ms,
    output logic [dat_pkg::USED_W-1:0]         o_entries_in_use
);
    import dat_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    t_entry        mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    t_entry        mem_wr_data;

    dat_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_dev_address     (i_dev_address),
        .i_address_kind    (i_address_kind),
        .i_entry_index     (i_entry_index),
        .i_enable_flag     (i_enable_flag),
        .i_now_ms          (i_now_ms),
        .i_signal_strength (i_signal_strength),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_found_index     (o_found_index),
        .o_interval_ms     (o_interval_ms),
        .o_entries_in_use  (o_entries_in_use),
        .o_mem_rd_en       (mem_rd_en),
        .o_mem_rd_addr     (mem_rd_addr),
        .i_mem_rd_data     (mem_rd_data),
        .o_mem_wr_en       (mem_wr_en),
        .o_mem_wr_addr     (mem_wr_addr),
        .o_mem_wr_data     (mem_wr_data)
    );

    dat_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

endmodule

`default_nettype wire

// File: tb/dat_checker.sv
`timescale 1ns / 100ps
// Result predictor and comparator for the device address table.
module dat_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd_valid,
    input  wire logic                              i_cmd_ready,
    input  wire logic [2:0]                        i_cmd,
    input  wire logic [dat_pkg::ADDR_W-1:0]        i_dev_address,
    input  wire logic [dat_pkg::KIND_W-1:0]        i_address_kind,
    input  wire logic [dat_pkg::IDX_W-1:0]         i_entry_index,
    input  wire logic                              i_enable_flag,
    input  wire logic [dat_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic signed [dat_pkg::RSSI_W-1:0] i_signal_strength,
    input  wire logic                              i_rsp_valid,
    input  wire logic                              i_rsp_ready,
    input  wire logic [dat_pkg::STATUS_W-1:0]      i_status,
    input  wire logic [dat_pkg::IDX_W-1:0]         i_found_index,
    input  wire logic [dat_pkg::TIME_W-1:0]        i_interval_ms,
    input  wire logic [dat_pkg::USED_W-1:0]        i_entries_in_use,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    import dat_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    index;
        logic [TIME_W-1:0]   interval;
        logic [USED_W-1:0]   used;
    } t_table_rsp;

    t_entry      slots [MAX_ENTRIES_DEF];
    int unsigned slot_count = 0;
    t_table_rsp  rsp_expected_q[$];
    t_table_rsp  oldest_rsp;
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = rsp_expected_q.size();

    function automatic int find_slot(input logic [ADDR_W-1:0] addr,
                                     input logic [KIND_W-1:0] kind);
        for (int i = 0; i < slot_count; i++) begin
            if (slots[i].addr == addr && slots[i].kind == kind) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_table_rsp run_table_command(
        input logic [2:0]               code,
        input logic [ADDR_W-1:0]        addr,
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         idx,
        input logic                     en,
        input logic [TIME_W-1:0]        now,
        input logic signed [RSSI_W-1:0] strength
    );
        t_table_rsp        r;
        int                hit;
        logic [TIME_W-1:0] prev;
        r.status   = ST_OK;
        r.index    = '0;
        r.interval = '0;
        hit        = find_slot(addr, kind);
        case (code)
            CMD_FIND: begin
                if (hit < 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.index = hit[IDX_W-1:0];
                end
            end
            CMD_ADD: begin
                if (hit >= 0) begin
                    r.status = ST_DUP;
                end else if (slot_count >= MAX_ENTRIES_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    slots[slot_count].addr      = addr;
                    slots[slot_count].kind      = kind;
                    slots[slot_count].enable    = 1'b1;
                    slots[slot_count].last_seen = '0;
                    slots[slot_count].rssi      = '0;
                    r.index    = slot_count[IDX_W-1:0];
                    slot_count = slot_count + 1;
                end
            end
            CMD_REMOVE: begin
                if (idx >= slot_count) begin
                    r.status = ST_MISS;
                end else begin
                    for (int i = idx; i + 1 < slot_count; i++) begin
                        slots[i] = slots[i + 1];
                    end
                    slot_count = slot_count - 1;
                end
            end
            CMD_SET_EN: begin
                if (idx >= slot_count) begin
                    r.status = ST_MISS;
                end else begin
                    slots[idx].enable = en;
                end
            end
            CMD_MARK: begin
                if (idx >= slot_count) begin
                    r.status   = ST_MISS;
                    r.interval = '1;
                end else begin
                    prev                  = slots[idx].last_seen;
                    slots[idx].last_seen  = now;
                    slots[idx].rssi       = strength;
                    r.interval            = (prev == '0) ? '1 : now - prev;
                end
            end
            default: begin
                r.status = ST_MISS;
            end
        endcase
        r.used = slot_count[USED_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_expected_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: result beat with nothing expected: status=%0d index=%0d",
                                 $realtime, i_status, i_found_index);
                    end
                    mismatch_count++;
                end else begin
                    oldest_rsp = rsp_expected_q.pop_front();
                    if (i_status !== oldest_rsp.status || i_found_index !== oldest_rsp.index ||
                        i_interval_ms !== oldest_rsp.interval ||
                        i_entries_in_use !== oldest_rsp.used) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: mismatch: expected status=%0d index=%0d interval=%h used=%0d",
                                     $realtime, oldest_rsp.status, oldest_rsp.index,
                                     oldest_rsp.interval, oldest_rsp.used);
                            $display("%0t:           got      status=%0d index=%0d interval=%h used=%0d",
                                     $realtime, i_status, i_found_index, i_interval_ms,
                                     i_entries_in_use);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                rsp_expected_q.push_back(run_table_command(i_cmd, i_dev_address,
                    i_address_kind, i_entry_index, i_enable_flag, i_now_ms,
                    i_signal_strength));
            end
        end
    end

endmodule

// File: tb/tb_device_address_table_unit.sv
`timescale 1ns / 100ps
// Top of the device address table testbench: clock, reset, command stimulus and verdict.
module tb_device_address_table_unit;

    import dat_pkg::*;

    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam int         POOL_SIZE  = 24;
    localparam int         RANDOM_CMDS = 500;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_ready;
    logic [2:0]               cmd_code = '0;
    logic [ADDR_W-1:0]        dev_address = '0;
    logic [KIND_W-1:0]        address_kind = '0;
    logic [IDX_W-1:0]         entry_index = '0;
    logic                     enable_flag = 1'b0;
    logic [TIME_W-1:0]        now_ms = '0;
    logic signed [RSSI_W-1:0] signal_strength = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    logic [STATUS_W-1:0]      rsp_status;
    logic [IDX_W-1:0]         rsp_found_index;
    logic [TIME_W-1:0]        rsp_interval_ms;
    logic [USED_W-1:0]        rsp_entries_in_use;
    int                       fail_count;
    int                       pending;

    logic [ADDR_W-1:0]        pool_addr [POOL_SIZE];
    logic [KIND_W-1:0]        pool_kind [POOL_SIZE];
    logic [TIME_W-1:0]        last_now = '0;
    bit                       send_fast = 1'b0;
    bit                       recv_fast = 1'b0;
    bit                       long_hold = 1'b0;

    device_address_table_unit uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (cmd_valid),
        .o_ready           (cmd_ready),
        .i_cmd             (cmd_code),
        .i_dev_address     (dev_address),
        .i_address_kind    (address_kind),
        .i_entry_index     (entry_index),
        .i_enable_flag     (enable_flag),
        .i_now_ms          (now_ms),
        .i_signal_strength (signal_strength),
        .o_valid           (rsp_valid),
        .i_ready           (rsp_ready),
        .o_status          (rsp_status),
        .o_found_index     (rsp_found_index),
        .o_interval_ms     (rsp_interval_ms),
        .o_entries_in_use  (rsp_entries_in_use)
    );

    dat_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd_ready       (cmd_ready),
        .i_cmd             (cmd_code),
        .i_dev_address     (dev_address),
        .i_address_kind    (address_kind),
        .i_entry_index     (entry_index),
        .i_enable_flag     (enable_flag),
        .i_now_ms          (now_ms),
        .i_signal_strength (signal_strength),
        .i_rsp_valid       (rsp_valid),
        .i_rsp_ready       (rsp_ready),
        .i_status          (rsp_status),
        .i_found_index     (rsp_found_index),
        .i_interval_ms     (rsp_interval_ms),
        .i_entries_in_use  (rsp_entries_in_use),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic issue_command(
        input logic [2:0]               code,
        input logic [ADDR_W-1:0]        addr,
        input logic [KIND_W-1:0]        kind,
        input logic [IDX_W-1:0]         idx,
        input logic                     en,
        input logic [TIME_W-1:0]        now,
        input logic signed [RSSI_W-1:0] strength
    );
        int gap;
        cmd_valid       <= 1'b1;
        cmd_code        <= code;
        dev_address     <= addr;
        address_kind    <= kind;
        entry_index     <= idx;
        enable_flag     <= en;
        now_ms          <= now;
        signal_strength <= strength;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        gap = (send_fast || long_hold) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_random_command(input int n);
        int                phase;
        int                pick;
        int                find_end;
        int                add_end;
        int                rm_end;
        int                slot;
        logic [2:0]        code;
        logic [63:0]       wide;
        logic [ADDR_W-1:0] addr;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] now;
        phase    = (n / 60) % 3;
        find_end = (phase == 1) ? 20 : 15;
        add_end  = (phase == 0) ? 65 : (phase == 1) ? 45 : 25;
        rm_end   = (phase == 1) ? 65 : 70;
        pick     = $urandom_range(0, 99);
        if (pick < find_end) begin
            code = CMD_FIND;
        end else if (pick < add_end) begin
            code = CMD_ADD;
        end else if (pick < rm_end) begin
            code = CMD_REMOVE;
        end else if (pick < 80) begin
            code = CMD_SET_EN;
        end else if (pick < 97) begin
            code = CMD_MARK;
        end else begin
            code = CMD_RSVD_5 + 3'($urandom_range(0, 2));
        end

        wide = {$urandom, $urandom};
        slot = $urandom_range(0, POOL_SIZE - 1);
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            addr = pool_addr[slot];
            kind = pool_kind[slot];
        end else if (pick == 8) begin
            addr = pool_addr[slot];
            kind = wide[63:56];
        end else begin
            addr = wide[ADDR_W-1:0];
            kind = wide[63:56];
        end

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            idx = IDX_W'($urandom_range(0, MAX_ENTRIES_DEF));
        end else if (pick < 9) begin
            idx = IDX_W'($urandom);
        end else begin
            idx = '1;
        end

        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            now = '0;
        end else if (pick == 1) begin
            now = '1;
        end else if (pick < 6) begin
            now = last_now + TIME_W'($urandom_range(0, 5000));
        end else begin
            now = $urandom;
        end
        last_now = now;

        wide = {$urandom, $urandom};
        issue_command(code, addr, kind, idx, wide[0], now, wide[15:8]);
    endtask

    initial begin
        int          got;
        int          stall;
        got = 0;
        wait (rst_n);
        forever begin
            if (got == 150) begin
                long_hold = 1'b1;
                stall     = 400;
            end else begin
                stall = recv_fast ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            got++;
            if (got % 40 == 0) begin
                recv_fast = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        logic [63:0] wide;
        for (int i = 0; i < POOL_SIZE; i++) begin
            wide         = {$urandom, $urandom};
            pool_addr[i] = wide[ADDR_W-1:0];
            pool_kind[i] = wide[63:56];
        end
        pool_addr[0] = '1;
        pool_kind[0] = '1;
        pool_addr[1] = '0;
        pool_kind[1] = '0;
        pool_addr[2] = '1;
        pool_kind[2] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every lookup and index misses.
        issue_command(CMD_FIND,   '1, '1, '0, 1'b0, '0, '0);
        issue_command(CMD_REMOVE, '0, '0, '0, 1'b0, '0, '0);
        issue_command(CMD_SET_EN, '0, '0, '0, 1'b1, '0, '0);
        issue_command(CMD_MARK,   '0, '0, '1, 1'b0, '1, '0);
        // Same address under two kinds, then a duplicate.
        issue_command(CMD_ADD,    '1, '1, '0, 1'b0, '0, '0);
        issue_command(CMD_ADD,    '0, '0, '0, 1'b0, '0, '0);
        issue_command(CMD_ADD,    '1, '0, '0, 1'b0, '0, '0);
        issue_command(CMD_ADD,    '1, '1, '0, 1'b0, '0, '0);
        issue_command(CMD_FIND,   '0, '0, '0, 1'b0, '0, '0);
        // First sighting, a wrapped interval, then the largest time.
        issue_command(CMD_MARK,   '0, '0, 8'd1, 1'b0, 32'd1000, -8'sd128);
        issue_command(CMD_MARK,   '0, '0, 8'd1, 1'b0, 32'd500, 8'sd127);
        issue_command(CMD_MARK,   '0, '0, 8'd1, 1'b0, '1, '0);
        issue_command(CMD_MARK,   '0, '0, 8'd1, 1'b0, '1, '1);
        issue_command(CMD_SET_EN, '0, '0, 8'd2, 1'b0, '0, '0);
        issue_command(CMD_SET_EN, '0, '0, 8'd2, 1'b1, '0, '0);
        issue_command(CMD_SET_EN, '0, '0, 8'd3, 1'b1, '0, '0);
        issue_command(CMD_REMOVE, '0, '0, 8'd0, 1'b0, '0, '0);
        issue_command(CMD_FIND,   '0, '0, '0, 1'b0, '0, '0);
        issue_command(CMD_RSVD_5, '1, '1, '1, 1'b1, '1, '1);
        issue_command(CMD_RSVD_6, '0, '0, '0, 1'b0, '0, '0);
        issue_command(CMD_RSVD_7, '1, '1, '1, 1'b1, '1, '1);
        issue_command(CMD_REMOVE, '0, '0, 8'd1, 1'b0, '0, '0);
        issue_command(CMD_REMOVE, '0, '0, 8'd0, 1'b0, '0, '0);

        for (int k = 0; k < RANDOM_CMDS; k++) begin
            if (k % 40 == 0) begin
                send_fast = ($urandom_range(0, 3) == 0);
            end
            issue_random_command(k);
        end
        cmd_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
